### rtl/lift_ramp_mode_controller_assert.svh
// Assertion macros used by the top level of the lift and ramp mode controller RTL.
`ifndef LIFT_RAMP_MODE_CONTROLLER_ASSERT_SVH
`define LIFT_RAMP_MODE_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/lrmc_pkg.sv
// Types, codes and constants of the lift and ramp mode controller.
`default_nettype none
package lrmc_pkg;

   localparam int POT_BITS_DEFAULT = 12;
   localparam int CFG_W            = 12;
   localparam int GAIN_W           = 8;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 5;
   localparam int HOLD_LIMIT       = 2047;

   typedef enum logic [2:0] {
      LM_INTAKING = 3'd0,
      LM_LOW      = 3'd1,
      LM_MID      = 3'd2,
      LM_HIGH     = 3'd3,
      LM_MANUAL   = 3'd4,
      LM_DEPLOY   = 3'd5
   } lift_mode_type;

   typedef enum logic [1:0] {
      RM_FREE   = 2'd0,
      RM_LOCKED = 2'd1,
      RM_MANUAL = 2'd2
   } ramp_mode_type;

   typedef enum logic [2:0] {
      CSR_RAMP_HOLD_TARGET    = 3'd0,
      CSR_RAMP_HOLD_GAIN      = 3'd1,
      CSR_RAMP_SLOW_THRESHOLD = 3'd2,
      CSR_RAMP_STOP_THRESHOLD = 3'd3,
      CSR_LOW_TOWER_POSITION  = 3'd4,
      CSR_MID_TOWER_POSITION  = 3'd5,
      CSR_HIGH_TOWER_POSITION = 3'd6,
      CSR_DEPLOY_POSITION     = 3'd7
   } csr_index_type;

   // master button bits
   localparam int BTN_UP    = 0;
   localparam int BTN_Y     = 1;
   localparam int BTN_RIGHT = 2;
   localparam int BTN_DOWN  = 3;
   localparam int BTN_LEFT  = 4;
   localparam int BTN_L1    = 5;
   localparam int BTN_L2    = 6;
   localparam int BTN_R1    = 7;
   localparam int BTN_R2    = 8;
   localparam int BTN_A     = 9;
   // partner button bits
   localparam int PBTN_R1   = 0;
   localparam int PBTN_L1   = 1;
   localparam int PBTN_A    = 2;

   localparam logic CMD_RAW = 1'b0;
   localparam logic CMD_ABS = 1'b1;
   localparam logic CMD_VEL = 1'b1;

   localparam logic signed [7:0] POWER_POS_FULL = 8'sd127;
   localparam logic signed [7:0] POWER_NEG_FULL = -8'sd127;
   localparam logic signed [7:0] POWER_INTAKE_A = 8'sd50;
   localparam logic signed [7:0] POWER_ZERO     = 8'sd0;
   localparam logic signed [7:0] POWER_SEEK_LOW = -8'sd10;
   localparam logic signed [7:0] STICK_MIN_RAW  = 8'sh80;

   localparam logic [6:0] SPEED_TOWER  = 7'd80;
   localparam logic [6:0] SPEED_DEPLOY = 7'd100;

   localparam logic signed [11:0] RAMP_FWD_FULL = 12'sd127;
   localparam logic signed [11:0] RAMP_FWD_SLOW = 12'sd20;
   localparam logic signed [11:0] RAMP_REV_FULL = -12'sd127;
   localparam logic signed [11:0] RAMP_ZERO     = 12'sd0;

   localparam logic [CFG_W-1:0]  RST_HOLD_TARGET = 12'd1350;
   localparam logic [GAIN_W-1:0] RST_HOLD_GAIN   = 8'd69;
   localparam logic [CFG_W-1:0]  RST_SLOW_THRESH = 12'd1150;
   localparam logic [CFG_W-1:0]  RST_STOP_THRESH = 12'd1700;
   localparam logic [CFG_W-1:0]  RST_LOW_TOWER   = 12'd270;
   localparam logic [CFG_W-1:0]  RST_MID_TOWER   = 12'd360;
   localparam logic [CFG_W-1:0]  RST_HIGH_TOWER  = 12'd500;
   localparam logic [CFG_W-1:0]  RST_DEPLOY      = 12'd100;

   typedef struct packed {
      logic [CFG_W-1:0]  ramp_hold_target;
      logic [GAIN_W-1:0] ramp_hold_gain;
      logic [CFG_W-1:0]  ramp_slow_threshold;
      logic [CFG_W-1:0]  ramp_stop_threshold;
      logic [CFG_W-1:0]  low_tower_position;
      logic [CFG_W-1:0]  mid_tower_position;
      logic [CFG_W-1:0]  high_tower_position;
      logic [CFG_W-1:0]  deploy_position;
   } cfg_type;

   typedef struct packed {
      lift_mode_type lift_mode;
      ramp_mode_type ramp_mode;
   } mode_state_type;

   typedef struct packed {
      logic signed [7:0]  intake_power;
      logic               arm_command_kind;
      logic signed [7:0]  arm_power;
      logic [11:0]        arm_target;
      logic [6:0]         arm_speed;
      logic               arm_rezero;
      logic               ramp_command_kind;
      logic signed [11:0] ramp_value;
      logic [2:0]         lift_mode_now;
      logic [1:0]         ramp_mode_now;
   } rsp_item_type;

   function automatic logic signed [7:0] stick_sat(input logic signed [7:0] raw);
      stick_sat = (raw == STICK_MIN_RAW) ? POWER_NEG_FULL : raw;
   endfunction

endpackage
`default_nettype wire

### rtl/lrmc_channel_if.sv
// Valid/ready channel interfaces for control ticks and command results.
`default_nettype none
interface lrmc_req_if #(
   parameter int POT_BITS = lrmc_pkg::POT_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [9:0]          master_buttons;
   logic [2:0]          partner_buttons;
   logic signed [7:0]   partner_left_x;
   logic signed [7:0]   partner_right_y;
   logic [POT_BITS-1:0] angle_pot;
   logic                lift_limit;
   logic                ramp_limit;

   modport source (
      output valid, master_buttons, partner_buttons, partner_left_x, partner_right_y,
             angle_pot, lift_limit, ramp_limit,
      input  ready
   );
   modport sink (
      input  valid, master_buttons, partner_buttons, partner_left_x, partner_right_y,
             angle_pot, lift_limit, ramp_limit,
      output ready
   );
endinterface

interface lrmc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [7:0]  intake_power;
   logic               arm_command_kind;
   logic signed [7:0]  arm_power;
   logic [11:0]        arm_target;
   logic [6:0]         arm_speed;
   logic               arm_rezero;
   logic               ramp_command_kind;
   logic signed [11:0] ramp_value;
   logic [2:0]         lift_mode_now;
   logic [1:0]         ramp_mode_now;

   modport source (
      output valid, intake_power, arm_command_kind, arm_power, arm_target, arm_speed,
             arm_rezero, ramp_command_kind, ramp_value, lift_mode_now, ramp_mode_now,
      input  ready
   );
   modport sink (
      input  valid, intake_power, arm_command_kind, arm_power, arm_target, arm_speed,
             arm_rezero, ramp_command_kind, ramp_value, lift_mode_now, ramp_mode_now,
      output ready
   );
endinterface
`default_nettype wire

### rtl/lrmc_csr.sv
// APB-style configuration register file of the lift and ramp mode controller.
`default_nettype none
module lrmc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lrmc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lrmc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [lrmc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output lrmc_pkg::cfg_type                      cfg
);
   import lrmc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_RAMP_HOLD_TARGET:    cfg_in.ramp_hold_target    = csr_pwdata[CFG_W-1:0];
            CSR_RAMP_HOLD_GAIN:      cfg_in.ramp_hold_gain      = csr_pwdata[GAIN_W-1:0];
            CSR_RAMP_SLOW_THRESHOLD: cfg_in.ramp_slow_threshold = csr_pwdata[CFG_W-1:0];
            CSR_RAMP_STOP_THRESHOLD: cfg_in.ramp_stop_threshold = csr_pwdata[CFG_W-1:0];
            CSR_LOW_TOWER_POSITION:  cfg_in.low_tower_position  = csr_pwdata[CFG_W-1:0];
            CSR_MID_TOWER_POSITION:  cfg_in.mid_tower_position  = csr_pwdata[CFG_W-1:0];
            CSR_HIGH_TOWER_POSITION: cfg_in.high_tower_position = csr_pwdata[CFG_W-1:0];
            CSR_DEPLOY_POSITION:     cfg_in.deploy_position     = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_hold_target    <= RST_HOLD_TARGET;
         cfg_ff.ramp_hold_gain      <= RST_HOLD_GAIN;
         cfg_ff.ramp_slow_threshold <= RST_SLOW_THRESH;
         cfg_ff.ramp_stop_threshold <= RST_STOP_THRESH;
         cfg_ff.low_tower_position  <= RST_LOW_TOWER;
         cfg_ff.mid_tower_position  <= RST_MID_TOWER;
         cfg_ff.high_tower_position <= RST_HIGH_TOWER;
         cfg_ff.deploy_position     <= RST_DEPLOY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         CSR_RAMP_HOLD_TARGET:    csr_prdata[CFG_W-1:0]  = cfg_ff.ramp_hold_target;
         CSR_RAMP_HOLD_GAIN:      csr_prdata[GAIN_W-1:0] = cfg_ff.ramp_hold_gain;
         CSR_RAMP_SLOW_THRESHOLD: csr_prdata[CFG_W-1:0]  = cfg_ff.ramp_slow_threshold;
         CSR_RAMP_STOP_THRESHOLD: csr_prdata[CFG_W-1:0]  = cfg_ff.ramp_stop_threshold;
         CSR_LOW_TOWER_POSITION:  csr_prdata[CFG_W-1:0]  = cfg_ff.low_tower_position;
         CSR_MID_TOWER_POSITION:  csr_prdata[CFG_W-1:0]  = cfg_ff.mid_tower_position;
         CSR_HIGH_TOWER_POSITION: csr_prdata[CFG_W-1:0]  = cfg_ff.high_tower_position;
         CSR_DEPLOY_POSITION:     csr_prdata[CFG_W-1:0]  = cfg_ff.deploy_position;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

### rtl/lrmc_datapath.sv
// Mode decode and arm, intake and ramp command logic for one control tick.
`default_nettype none
module lrmc_datapath #(
   parameter int POT_BITS = lrmc_pkg::POT_BITS_DEFAULT
) (
   input  lrmc_pkg::mode_state_type   state,
   input  lrmc_pkg::cfg_type          cfg,
   input  wire logic [9:0]            master_buttons,
   input  wire logic [2:0]            partner_buttons,
   input  wire logic signed [7:0]     partner_left_x,
   input  wire logic signed [7:0]     partner_right_y,
   input  wire logic [POT_BITS-1:0]   angle_pot,
   input  wire logic                  lift_limit,
   input  wire logic                  ramp_limit,
   output lrmc_pkg::mode_state_type   state_next,
   output lrmc_pkg::rsp_item_type     result
);
   import lrmc_pkg::*;

   localparam int CMP_W = (POT_BITS > CFG_W) ? POT_BITS : CFG_W;

   logic [CMP_W-1:0]         pot_ext;
   logic [CMP_W-1:0]         target_ext;
   logic [CMP_W-1:0]         slow_ext;
   logic [CMP_W-1:0]         stop_ext;
   logic signed [CMP_W:0]    hold_err;
   logic [CMP_W-1:0]         hold_mag;
   logic [CMP_W+GAIN_W-1:0]  hold_prod;
   logic [CMP_W-1:0]         hold_q;
   logic [11:0]              hold_sat;
   logic signed [11:0]       hold_vel;
   logic signed [7:0]        lx_sat;
   logic signed [7:0]        ry_sat;
   lift_mode_type            lift_nx;
   ramp_mode_type            ramp_nx;

   assign pot_ext    = CMP_W'(angle_pot);
   assign target_ext = CMP_W'(cfg.ramp_hold_target);
   assign slow_ext   = CMP_W'(cfg.ramp_slow_threshold);
   assign stop_ext   = CMP_W'(cfg.ramp_stop_threshold);

   assign hold_err  = $signed({1'b0, target_ext}) - $signed({1'b0, pot_ext});
   assign hold_mag  = hold_err[CMP_W] ? CMP_W'(-hold_err) : CMP_W'(hold_err);
   assign hold_prod = (CMP_W+GAIN_W)'(hold_mag) * (CMP_W+GAIN_W)'(cfg.ramp_hold_gain);
   assign hold_q    = hold_prod[CMP_W+GAIN_W-1:GAIN_W];
   assign hold_sat  = (hold_q > CMP_W'(HOLD_LIMIT)) ? 12'(HOLD_LIMIT) : hold_q[11:0];
   assign hold_vel  = hold_err[CMP_W] ? $signed(12'd0 - hold_sat) : $signed(hold_sat);

   assign lx_sat = stick_sat(partner_left_x);
   assign ry_sat = stick_sat(partner_right_y);

   always_comb begin
      lift_nx = state.lift_mode;
      ramp_nx = state.ramp_mode;
      if (master_buttons[BTN_UP]) begin
         lift_nx = LM_HIGH;
      end else if (master_buttons[BTN_Y]) begin
         lift_nx = LM_DEPLOY;
      end else if (master_buttons[BTN_RIGHT]) begin
         lift_nx = LM_MID;
      end else if (master_buttons[BTN_DOWN]) begin
         lift_nx = LM_LOW;
      end else if (master_buttons[BTN_LEFT]) begin
         lift_nx = LM_INTAKING;
      end else if (master_buttons[BTN_L1] || master_buttons[BTN_L2]) begin
         ramp_nx = RM_FREE;
      end else if (partner_left_x != 8'sd0) begin
         ramp_nx = RM_MANUAL;
      end else if (partner_right_y != 8'sd0) begin
         lift_nx = LM_MANUAL;
      end

      result = '0;

      // first roller gets the negated choice
      if (master_buttons[BTN_R1] || partner_buttons[PBTN_R1]) begin
         result.intake_power = POWER_NEG_FULL;
      end else if (master_buttons[BTN_R2] || partner_buttons[PBTN_L1]) begin
         result.intake_power = POWER_POS_FULL;
      end else if (master_buttons[BTN_A] || partner_buttons[PBTN_A]) begin
         result.intake_power = POWER_INTAKE_A;
      end else begin
         result.intake_power = POWER_ZERO;
      end

      case (lift_nx)
         LM_INTAKING: begin
            ramp_nx = RM_FREE;
            if (lift_limit) begin
               result.arm_power  = POWER_SEEK_LOW;
               result.arm_rezero = 1'b1;
            end else begin
               result.arm_power  = POWER_NEG_FULL;
            end
         end
         LM_LOW: begin
            ramp_nx                 = RM_LOCKED;
            result.arm_command_kind = CMD_ABS;
            result.arm_target       = cfg.low_tower_position;
            result.arm_speed        = SPEED_TOWER;
         end
         LM_MID: begin
            ramp_nx                 = RM_LOCKED;
            result.arm_command_kind = CMD_ABS;
            result.arm_target       = cfg.mid_tower_position;
            result.arm_speed        = SPEED_TOWER;
         end
         LM_HIGH: begin
            ramp_nx                 = RM_LOCKED;
            result.arm_command_kind = CMD_ABS;
            result.arm_target       = cfg.high_tower_position;
            result.arm_speed        = SPEED_TOWER;
         end
         LM_MANUAL: begin
            result.arm_power = ry_sat;
         end
         LM_DEPLOY: begin
            result.arm_command_kind = CMD_ABS;
            result.arm_target       = cfg.deploy_position;
            result.arm_speed        = SPEED_DEPLOY;
         end
         default: ;
      endcase

      case (ramp_nx)
         RM_FREE: begin
            if (master_buttons[BTN_L1]) begin
               if (pot_ext > slow_ext) begin
                  if (pot_ext > stop_ext) begin
                     result.ramp_command_kind = CMD_RAW;
                     result.ramp_value        = RAMP_ZERO;
                  end else begin
                     result.ramp_command_kind = CMD_VEL;
                     result.ramp_value        = RAMP_FWD_SLOW;
                  end
               end else begin
                  result.ramp_command_kind = CMD_VEL;
                  result.ramp_value        = RAMP_FWD_FULL;
               end
            end else if (master_buttons[BTN_L2]) begin
               result.ramp_command_kind = CMD_VEL;
               result.ramp_value        = ramp_limit ? RAMP_ZERO : RAMP_REV_FULL;
            end else begin
               result.ramp_command_kind = CMD_RAW;
               result.ramp_value        = RAMP_ZERO;
            end
         end
         RM_LOCKED: begin
            result.ramp_command_kind = CMD_VEL;
            result.ramp_value        = hold_vel;
         end
         RM_MANUAL: begin
            result.ramp_command_kind = CMD_RAW;
            result.ramp_value        = {{4{lx_sat[7]}}, lx_sat};
         end
         default: ;
      endcase

      result.lift_mode_now = lift_nx;
      result.ramp_mode_now = ramp_nx;
      state_next.lift_mode = lift_nx;
      state_next.ramp_mode = ramp_nx;
   end

endmodule
`default_nettype wire

### rtl/lift_ramp_mode_controller.sv
// Top level of the lift and ramp mode controller.
//
// Each transaction on req_chan is one control tick: buttons, sticks, ramp pot
// and limit switches. Each tick yields exactly one transaction on rsp_chan
// with the intake, arm and ramp commands and the lift and ramp modes in force.
// The csr_ port is an APB-style register file holding setpoints, gain,
// thresholds and arm positions; write it only while no tick is in flight.
// Path: a tick accepted on req_chan enters the input register, then the result
// register, which drives rsp_chan. Throughput: one tick per cycle while rsp_chan
// takes each result, set by the single pass from the input register to the
// result register, which also updates the lift and ramp mode registers for the next tick.
// Reset: lift mode goes to intaking, ramp mode to free, configuration to its
// default values, and any tick in flight is dropped.
// Stall: a result waiting on rsp_chan.ready is held; one more tick fills the
// input register, then req_chan.ready drops until the result is taken.
`default_nettype none
`include "lift_ramp_mode_controller_assert.svh"
module lift_ramp_mode_controller #(
   parameter int POT_BITS = lrmc_pkg::POT_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lrmc_req_if.sink                               req_chan,
   lrmc_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lrmc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lrmc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [lrmc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import lrmc_pkg::*;

   cfg_type             cfg;
   mode_state_type      state_ff;
   mode_state_type      state_in;
   mode_state_type      state_next;
   rsp_item_type        result;
   rsp_item_type        rsp_item_ff;
   rsp_item_type        rsp_item_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic                s1_advance;
   logic                req_take;
   logic                lift_is_tower;
   logic                lift_is_intaking;
   logic                ramp_is_locked;
   logic                ramp_is_free;
   logic [9:0]          master_buttons_ff;
   logic [9:0]          master_buttons_in;
   logic [2:0]          partner_buttons_ff;
   logic [2:0]          partner_buttons_in;
   logic signed [7:0]   partner_left_x_ff;
   logic signed [7:0]   partner_left_x_in;
   logic signed [7:0]   partner_right_y_ff;
   logic signed [7:0]   partner_right_y_in;
   logic [POT_BITS-1:0] angle_pot_ff;
   logic [POT_BITS-1:0] angle_pot_in;
   logic                lift_limit_ff;
   logic                lift_limit_in;
   logic                ramp_limit_ff;
   logic                ramp_limit_in;

   lrmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lrmc_datapath #(
      .POT_BITS (POT_BITS)
   ) u_datapath (
      .state           (state_ff),
      .cfg             (cfg),
      .master_buttons  (master_buttons_ff),
      .partner_buttons (partner_buttons_ff),
      .partner_left_x  (partner_left_x_ff),
      .partner_right_y (partner_right_y_ff),
      .angle_pot       (angle_pot_ff),
      .lift_limit      (lift_limit_ff),
      .ramp_limit      (ramp_limit_ff),
      .state_next      (state_next),
      .result          (result)
   );

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in        = s1_valid_ff;
      out_valid_in       = out_valid_ff;
      state_in           = state_ff;
      rsp_item_in        = rsp_item_ff;
      master_buttons_in  = master_buttons_ff;
      partner_buttons_in = partner_buttons_ff;
      partner_left_x_in  = partner_left_x_ff;
      partner_right_y_in = partner_right_y_ff;
      angle_pot_in       = angle_pot_ff;
      lift_limit_in      = lift_limit_ff;
      ramp_limit_in      = ramp_limit_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_advance) begin
         out_valid_in = 1'b1;
         rsp_item_in  = result;
         state_in     = state_next;
         s1_valid_in  = 1'b0;
      end
      if (req_take) begin
         s1_valid_in        = 1'b1;
         master_buttons_in  = req_chan.master_buttons;
         partner_buttons_in = req_chan.partner_buttons;
         partner_left_x_in  = req_chan.partner_left_x;
         partner_right_y_in = req_chan.partner_right_y;
         angle_pot_in       = req_chan.angle_pot;
         lift_limit_in      = req_chan.lift_limit;
         ramp_limit_in      = req_chan.ramp_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.lift_mode <= LM_INTAKING;
         state_ff.ramp_mode <= RM_FREE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff        <= rsp_item_in;
      master_buttons_ff  <= master_buttons_in;
      partner_buttons_ff <= partner_buttons_in;
      partner_left_x_ff  <= partner_left_x_in;
      partner_right_y_ff <= partner_right_y_in;
      angle_pot_ff       <= angle_pot_in;
      lift_limit_ff      <= lift_limit_in;
      ramp_limit_ff      <= ramp_limit_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.intake_power      = rsp_item_ff.intake_power;
   assign rsp_chan.arm_command_kind  = rsp_item_ff.arm_command_kind;
   assign rsp_chan.arm_power         = rsp_item_ff.arm_power;
   assign rsp_chan.arm_target        = rsp_item_ff.arm_target;
   assign rsp_chan.arm_speed         = rsp_item_ff.arm_speed;
   assign rsp_chan.arm_rezero        = rsp_item_ff.arm_rezero;
   assign rsp_chan.ramp_command_kind = rsp_item_ff.ramp_command_kind;
   assign rsp_chan.ramp_value        = rsp_item_ff.ramp_value;
   assign rsp_chan.lift_mode_now     = rsp_item_ff.lift_mode_now;
   assign rsp_chan.ramp_mode_now     = rsp_item_ff.ramp_mode_now;

   assign lift_is_tower    = state_ff.lift_mode inside {LM_LOW, LM_MID, LM_HIGH};
   assign lift_is_intaking = (state_ff.lift_mode == LM_INTAKING);
   assign ramp_is_locked   = (state_ff.ramp_mode == RM_LOCKED);
   assign ramp_is_free     = (state_ff.ramp_mode == RM_FREE);

   `ASSERT_IMPLY(a_tower_locks_ramp, clock, reset, lift_is_tower, ramp_is_locked)
   `ASSERT_IMPLY(a_intaking_frees_ramp, clock, reset, lift_is_intaking, ramp_is_free)
   `ASSERT_NEXT(a_stalled_tick_kept, clock, reset, (s1_valid_ff && !s1_advance), s1_valid_ff)
   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_take, s1_valid_ff)

endmodule
`default_nettype wire

### tb/lift_ramp_mode_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the lift and ramp mode controller.
module lift_ramp_mode_controller_tb;
   import lrmc_pkg::*;

   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 8;

   localparam cfg_type CFG_DEFAULT = '{12'd1350, 8'd69, 12'd1150, 12'd1700,
                                       12'd270, 12'd360, 12'd500, 12'd100};

   typedef struct packed {
      logic [9:0]        btn;
      logic [2:0]        partner;
      logic signed [7:0] left_x;
      logic signed [7:0] right_y;
      logic [11:0]       pot;
      logic              lift_lim;
      logic              ramp_lim;
   } tick_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lrmc_req_if req_chan ();
   lrmc_rsp_if rsp_chan ();

   lift_ramp_mode_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lift_mode_type lift_shadow;
   ramp_mode_type ramp_shadow;
   cfg_type       cfg_shadow;
   rsp_item_type  command_q[$];
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   bit            sender_idle_en = 1'b1;
   bit            sink_idle_en = 1'b1;
   bit            long_hold_req = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [7:0] stick_power(logic signed [7:0] raw);
      return (raw == 8'sh80) ? -8'sd127 : raw;
   endfunction

   function automatic rsp_item_type predict_command(tick_type t);
      rsp_item_type r;
      int           chosen;
      int           err;
      int           mag;
      int           vel;
      r = '0;
      if (t.btn[BTN_UP]) lift_shadow = LM_HIGH;
      else if (t.btn[BTN_Y]) lift_shadow = LM_DEPLOY;
      else if (t.btn[BTN_RIGHT]) lift_shadow = LM_MID;
      else if (t.btn[BTN_DOWN]) lift_shadow = LM_LOW;
      else if (t.btn[BTN_LEFT]) lift_shadow = LM_INTAKING;
      else if (t.btn[BTN_L1] || t.btn[BTN_L2]) ramp_shadow = RM_FREE;
      else if (t.left_x != 0) ramp_shadow = RM_MANUAL;
      else if (t.right_y != 0) lift_shadow = LM_MANUAL;

      if (t.btn[BTN_R1] || t.partner[PBTN_R1]) chosen = 127;
      else if (t.btn[BTN_R2] || t.partner[PBTN_L1]) chosen = -127;
      else if (t.btn[BTN_A] || t.partner[PBTN_A]) chosen = -50;
      else chosen = 0;
      r.intake_power = 8'(-chosen);

      r.arm_command_kind = CMD_RAW;
      case (lift_shadow)
         LM_INTAKING: begin
            ramp_shadow = RM_FREE;
            r.arm_power = t.lift_lim ? -8'sd10 : -8'sd127;
            r.arm_rezero = t.lift_lim;
         end
         LM_LOW, LM_MID, LM_HIGH: begin
            ramp_shadow = RM_LOCKED;
            r.arm_command_kind = CMD_ABS;
            r.arm_speed = 7'd80;
            if (lift_shadow == LM_LOW) r.arm_target = cfg_shadow.low_tower_position;
            else if (lift_shadow == LM_MID) r.arm_target = cfg_shadow.mid_tower_position;
            else r.arm_target = cfg_shadow.high_tower_position;
         end
         LM_MANUAL: begin
            r.arm_power = stick_power(t.right_y);
         end
         LM_DEPLOY: begin
            r.arm_command_kind = CMD_ABS;
            r.arm_target = cfg_shadow.deploy_position;
            r.arm_speed = 7'd100;
         end
         default: ;
      endcase

      r.ramp_command_kind = CMD_RAW;
      case (ramp_shadow)
         RM_FREE: begin
            if (t.btn[BTN_L1]) begin
               if (t.pot > cfg_shadow.ramp_slow_threshold) begin
                  if (t.pot <= cfg_shadow.ramp_stop_threshold) begin
                     r.ramp_command_kind = CMD_VEL;
                     r.ramp_value = 12'sd20;
                  end
               end else begin
                  r.ramp_command_kind = CMD_VEL;
                  r.ramp_value = 12'sd127;
               end
            end else if (t.btn[BTN_L2]) begin
               r.ramp_command_kind = CMD_VEL;
               r.ramp_value = t.ramp_lim ? 12'sd0 : -12'sd127;
            end
         end
         RM_LOCKED: begin
            err = int'(cfg_shadow.ramp_hold_target) - int'(t.pot);
            mag = (err < 0) ? -err : err;
            vel = (mag * int'(cfg_shadow.ramp_hold_gain)) >>> 8;
            if (vel > HOLD_LIMIT) vel = HOLD_LIMIT;
            r.ramp_command_kind = CMD_VEL;
            r.ramp_value = 12'((err < 0) ? -vel : vel);
         end
         RM_MANUAL: begin
            r.ramp_value = 12'(stick_power(t.left_x));
         end
         default: ;
      endcase

      r.lift_mode_now = lift_shadow;
      r.ramp_mode_now = ramp_shadow;
      return r;
   endfunction

   function automatic tick_type make_tick(int btn, int partner, int lx, int ry, int pot,
                                          int lift_lim, int ramp_lim);
      tick_type t;
      t.btn = 10'(btn);
      t.partner = 3'(partner);
      t.left_x = 8'(lx);
      t.right_y = 8'(ry);
      t.pot = 12'(pot);
      t.lift_lim = lift_lim[0];
      t.ramp_lim = ramp_lim[0];
      return t;
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      int       p;
      if ($urandom_range(0, 9) == 0) begin
         t.btn = 10'($urandom);
      end else begin
         for (int i = 0; i < 10; i++) t.btn[i] = ($urandom_range(0, 7) == 0);
      end
      t.partner = $urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : 3'd0;
      t.left_x = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'sd0;
      t.right_y = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'sd0;
      case ($urandom_range(0, 5))
         0: p = $urandom_range(0, 4095);
         1: p = int'(cfg_shadow.ramp_slow_threshold) + int'($urandom_range(0, 4)) - 2;
         2: p = int'(cfg_shadow.ramp_stop_threshold) + int'($urandom_range(0, 4)) - 2;
         3: p = int'(cfg_shadow.ramp_hold_target) + int'($urandom_range(0, 600)) - 300;
         4: p = $urandom_range(0, 3);
         default: p = 4095 - int'($urandom_range(0, 3));
      endcase
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      t.pot = 12'(p);
      t.lift_lim = 1'($urandom_range(0, 1));
      t.ramp_lim = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic string show_command(rsp_item_type r);
      return $sformatf("intake=%0d arm=%0d/%0d/%0d/%0d rezero=%0d ramp=%0d/%0d modes=%0d/%0d",
                       r.intake_power, r.arm_command_kind, r.arm_power, r.arm_target,
                       r.arm_speed, r.arm_rezero, r.ramp_command_kind, r.ramp_value,
                       r.lift_mode_now, r.ramp_mode_now);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] shadow_value(csr_index_type idx);
      case (idx)
         CSR_RAMP_HOLD_TARGET:    return CSR_DATA_W'(cfg_shadow.ramp_hold_target);
         CSR_RAMP_HOLD_GAIN:      return CSR_DATA_W'(cfg_shadow.ramp_hold_gain);
         CSR_RAMP_SLOW_THRESHOLD: return CSR_DATA_W'(cfg_shadow.ramp_slow_threshold);
         CSR_RAMP_STOP_THRESHOLD: return CSR_DATA_W'(cfg_shadow.ramp_stop_threshold);
         CSR_LOW_TOWER_POSITION:  return CSR_DATA_W'(cfg_shadow.low_tower_position);
         CSR_MID_TOWER_POSITION:  return CSR_DATA_W'(cfg_shadow.mid_tower_position);
         CSR_HIGH_TOWER_POSITION: return CSR_DATA_W'(cfg_shadow.high_tower_position);
         default:                 return CSR_DATA_W'(cfg_shadow.deploy_position);
      endcase
   endfunction

   task automatic note_failure(string msg);
      if (mismatch_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic send_tick(tick_type t);
      if (sender_idle_en && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.master_buttons <= t.btn;
      req_chan.partner_buttons <= t.partner;
      req_chan.partner_left_x <= t.left_x;
      req_chan.partner_right_y <= t.right_y;
      req_chan.angle_pot <= t.pot;
      req_chan.lift_limit <= t.lift_lim;
      req_chan.ramp_limit <= t.ramp_lim;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      command_q.push_back(predict_command(t));
   endtask

   task automatic drain_commands();
      req_chan.valid <= 1'b0;
      while (command_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(csr_index_type idx, bit is_write, logic [11:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      if (idx == CSR_RAMP_HOLD_GAIN) data[7:0] = value[7:0];
      else data[11:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (is_write) begin
         case (idx)
            CSR_RAMP_HOLD_TARGET:    cfg_shadow.ramp_hold_target = data[11:0];
            CSR_RAMP_HOLD_GAIN:      cfg_shadow.ramp_hold_gain = data[7:0];
            CSR_RAMP_SLOW_THRESHOLD: cfg_shadow.ramp_slow_threshold = data[11:0];
            CSR_RAMP_STOP_THRESHOLD: cfg_shadow.ramp_stop_threshold = data[11:0];
            CSR_LOW_TOWER_POSITION:  cfg_shadow.low_tower_position = data[11:0];
            CSR_MID_TOWER_POSITION:  cfg_shadow.mid_tower_position = data[11:0];
            CSR_HIGH_TOWER_POSITION: cfg_shadow.high_tower_position = data[11:0];
            default:                 cfg_shadow.deploy_position = data[11:0];
         endcase
      end else if (csr_prdata !== shadow_value(idx)) begin
         note_failure($sformatf("register %s read %0h, expected %0h", idx.name(),
                                csr_prdata, shadow_value(idx)));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(cfg_type c);
      csr_index_type idx;
      drain_commands();
      csr_access(CSR_RAMP_HOLD_TARGET, 1'b1, c.ramp_hold_target);
      csr_access(CSR_RAMP_HOLD_GAIN, 1'b1, 12'(c.ramp_hold_gain));
      csr_access(CSR_RAMP_SLOW_THRESHOLD, 1'b1, c.ramp_slow_threshold);
      csr_access(CSR_RAMP_STOP_THRESHOLD, 1'b1, c.ramp_stop_threshold);
      csr_access(CSR_LOW_TOWER_POSITION, 1'b1, c.low_tower_position);
      csr_access(CSR_MID_TOWER_POSITION, 1'b1, c.mid_tower_position);
      csr_access(CSR_HIGH_TOWER_POSITION, 1'b1, c.high_tower_position);
      csr_access(CSR_DEPLOY_POSITION, 1'b1, c.deploy_position);
      idx = idx.first();
      do begin
         csr_access(idx, 1'b0, 12'd0);
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   task automatic run_random_ticks(int count);
      repeat (count) send_tick(random_tick());
   endtask

   task automatic test_directed_ticks();
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(0, 0, 0, 0, 4095, 1, 1));
      send_tick(make_tick((1 << BTN_L1) | (1 << BTN_R1), 0, 0, 0, 1150, 0, 0));
      send_tick(make_tick((1 << BTN_L1) | (1 << BTN_R2), 0, 0, 0, 1151, 0, 0));
      send_tick(make_tick((1 << BTN_L1) | (1 << BTN_A), 0, 0, 0, 1700, 0, 0));
      send_tick(make_tick(1 << BTN_L1, 1 << PBTN_R1, 0, 0, 1701, 0, 0));
      send_tick(make_tick(1 << BTN_L2, 1 << PBTN_L1, 0, 0, 2000, 0, 0));
      send_tick(make_tick(1 << BTN_L2, 1 << PBTN_A, 0, 0, 2000, 0, 1));
      send_tick(make_tick(10'h3E0, 7, 0, 0, 4095, 1, 0));
      send_tick(make_tick(1 << BTN_DOWN, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(1 << BTN_RIGHT, 0, 0, 0, 4095, 0, 0));
      send_tick(make_tick(1 << BTN_UP, 0, 0, 0, 1350, 0, 0));
      send_tick(make_tick(1 << BTN_Y, 0, 0, 0, 200, 0, 0));
      send_tick(make_tick(0, 0, -128, 0, 200, 0, 0));
      send_tick(make_tick(0, 0, 127, 5, 200, 0, 0));
      send_tick(make_tick(0, 0, 0, -128, 200, 1, 0));
      send_tick(make_tick(0, 0, 0, 127, 200, 0, 0));
      send_tick(make_tick(1 << BTN_L1, 0, -1, 3, 0, 0, 0));
      send_tick(make_tick(1 << BTN_LEFT, 0, 0, -5, 0, 1, 0));
      send_tick(make_tick(1 << BTN_Y, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(1 << BTN_L2, 0, 0, 0, 0, 0, 1));
      send_tick(make_tick(10'h3FF, 7, -128, -128, 4095, 1, 1));
      send_tick(make_tick(10'h3FE, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(10'h3FC, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_config_sweep();
      cfg_type c;
      apply_config('1);
      run_random_ticks(120);
      apply_config('0);
      run_random_ticks(120);
      repeat (4) begin
         c.ramp_hold_target = 12'($urandom);
         c.ramp_hold_gain = 8'($urandom);
         c.ramp_slow_threshold = 12'($urandom);
         c.ramp_stop_threshold = 12'($urandom);
         c.low_tower_position = 12'($urandom);
         c.mid_tower_position = 12'($urandom);
         c.high_tower_position = 12'($urandom);
         c.deploy_position = 12'($urandom);
         apply_config(c);
         run_random_ticks(120);
      end
   endtask

   task automatic test_backpressure();
      sender_idle_en = 1'b0;
      long_hold_req = 1'b1;
      run_random_ticks(24);
      sender_idle_en = 1'b1;
   endtask

   task automatic test_random_stream();
      apply_config(CFG_DEFAULT);
      run_random_ticks(600);
      sender_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      run_random_ticks(150);
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_chan.ready <= 1'b0;
         end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 13) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.intake_power = rsp_chan.intake_power;
         got.arm_command_kind = rsp_chan.arm_command_kind;
         got.arm_power = rsp_chan.arm_power;
         got.arm_target = rsp_chan.arm_target;
         got.arm_speed = rsp_chan.arm_speed;
         got.arm_rezero = rsp_chan.arm_rezero;
         got.ramp_command_kind = rsp_chan.ramp_command_kind;
         got.ramp_value = rsp_chan.ramp_value;
         got.lift_mode_now = rsp_chan.lift_mode_now;
         got.ramp_mode_now = rsp_chan.ramp_mode_now;
         if (command_q.size() == 0) begin
            note_failure($sformatf("unexpected result %s", show_command(got)));
         end else begin
            want = command_q.pop_front();
            if (got.intake_power !== want.intake_power
                || got.arm_command_kind !== want.arm_command_kind
                || got.arm_power !== want.arm_power
                || got.arm_target !== want.arm_target
                || got.arm_speed !== want.arm_speed
                || got.arm_rezero !== want.arm_rezero
                || got.ramp_command_kind !== want.ramp_command_kind
                || got.ramp_value !== want.ramp_value
                || got.lift_mode_now !== want.lift_mode_now
                || got.ramp_mode_now !== want.ramp_mode_now)
               note_failure($sformatf("expected %s, got %s", show_command(want),
                                      show_command(got)));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[lift_ramp_mode_controller] ERROR");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.master_buttons <= '0;
      req_chan.partner_buttons <= '0;
      req_chan.partner_left_x <= '0;
      req_chan.partner_right_y <= '0;
      req_chan.angle_pot <= '0;
      req_chan.lift_limit <= 1'b0;
      req_chan.ramp_limit <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      lift_shadow = LM_INTAKING;
      ramp_shadow = RM_FREE;
      cfg_shadow = CFG_DEFAULT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ticks();
      test_config_sweep();
      test_backpressure();
      test_random_stream();

      drain_commands();
      if (mismatch_count == 0 && command_q.size() == 0)
         $display("[lift_ramp_mode_controller] OK");
      else
         $display("[lift_ramp_mode_controller] ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/lrmc_pkg.sv
rtl/lrmc_channel_if.sv
rtl/lrmc_csr.sv
rtl/lrmc_datapath.sv
rtl/lift_ramp_mode_controller.sv
tb/lift_ramp_mode_controller_tb.sv
